// ===== rtl/dbsel_pkg.sv =====
// ----------------------------------------------------------------------------
// dbsel_pkg
// Shared types and constants of the debounced button selector.
// ----------------------------------------------------------------------------
package dbsel_pkg;

  localparam int unsigned BtnW    = 16;  // width of the button and LED vectors
  localparam int unsigned TimeW   = 32;
  localparam int unsigned DtimeW  = 16;
  localparam int unsigned IdW     = 5;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] CFG_DEBOUNCE_TIME = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_LATCH_MODE    = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_LOG_RAW       = 2'd2;

  localparam logic [DtimeW-1:0] DTIME_RESET = 16'd30;

  // status a cell reports for the current word
  typedef struct packed {
    logic deb_new;
    logic raw_chg;
    logic deb_chg;
  } cell_stat_t;

endpackage

// ===== rtl/dbsel_cell.sv =====
// ----------------------------------------------------------------------------
// dbsel_cell
// One button: raw history, change timestamp, debounced level and a stage of
// the selection chain (a press edge here overrides lower-numbered buttons).
// ----------------------------------------------------------------------------
module dbsel_cell
  import dbsel_pkg::*;
#(
  parameter logic [4:0] ID = 5'd1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              raw_i,
  input  logic [TimeW-1:0]  now_i,
  input  logic [DtimeW-1:0] dtime_i,
  input  logic [IdW-1:0]    sel_i,
  output logic [IdW-1:0]    sel_o,
  output cell_stat_t        st_o
);

  logic             raw_prev_q;
  logic             deb_q;
  logic [TimeW-1:0] t_q;

  logic             raw_chg;
  logic [TimeW-1:0] elapsed;
  logic             take;
  logic             deb_new;

  always_comb begin
    raw_chg = raw_i ^ raw_prev_q;
    // a fresh change restarts the timer on this very tick
    elapsed = raw_chg ? '0 : (now_i - t_q);
    take    = (elapsed >= {{(TimeW-DtimeW){1'b0}}, dtime_i}) && (raw_i != deb_q);
    deb_new = take ? raw_i : deb_q;
    sel_o   = (deb_q && !deb_new) ? ID : sel_i;
    st_o    = '{deb_new: deb_new, raw_chg: raw_chg, deb_chg: take};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_prev_q <= 1'b1;
      deb_q      <= 1'b1;
      t_q        <= '0;
    end else if (en_i) begin
      raw_prev_q <= raw_i;
      deb_q      <= deb_new;
      if (raw_chg) begin
        t_q <= now_i;
      end
    end
  end

endmodule

// ===== rtl/debounced_one_hot_button_selector_top.sv =====
// ----------------------------------------------------------------------------
// debounced_one_hot_button_selector_top
// Debounces an active-low button vector against millisecond timestamps and
// keeps a one-hot selection of the most recently pressed button.
// ----------------------------------------------------------------------------
// The result word is registered and valid in the cycle after its input word is accepted.
// Throughput: one word per cycle while the output is not stalled; the per-button cells
//   and the selection chain through them are combinational.
// Reset: all buttons released, timestamps zero, nothing selected,
//   debounce_time 30, latch_mode 1, raw-change logging off.
module debounced_one_hot_button_selector_top
  import dbsel_pkg::*;
#(
  parameter int unsigned BUTTONS = 16,
  parameter int unsigned LEDS    = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [DtimeW-1:0]  cfg_wdata_i,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  // [15:0] raw_buttons, [47:16] now_ms
  input  logic [47:0]        s_axis_tdata,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // [15:0] debounced_buttons, [20:16] active_id, [36:21] led_pattern,
  // [37] raw_changed, [38] debounce_changed, [39] selection_changed,
  // [40] log_request, [47:41] zero
  output logic [47:0]        m_axis_tdata
);

  localparam int unsigned NBTN = (BUTTONS > BtnW) ? BtnW : ((BUTTONS < 1) ? 1 : BUTTONS);
  localparam int unsigned NLED = (LEDS > BtnW) ? BtnW : ((LEDS < 1) ? 1 : LEDS);

  logic [DtimeW-1:0] dtime_q;
  logic              latch_q;
  logic              lograw_q;
  logic [IdW-1:0]    sel_q;
  logic [IdW-1:0]    sel_d;
  logic              out_valid_q;
  logic [47:0]       out_q;

  logic [BtnW-1:0]  raw;
  logic [TimeW-1:0] now;
  logic             accept;

  logic [IdW-1:0]   sel_chain [0:NBTN];
  logic [BtnW-1:0]  deb_vec;
  logic [NBTN-1:0]  raw_chg_vec;
  logic [NBTN-1:0]  deb_chg_vec;
  logic             raw_chg, deb_chg, sel_chg, log_req;
  logic [BtnW-1:0]  led;

  assign raw    = s_axis_tdata[15:0];
  assign now    = s_axis_tdata[47:16];
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept = s_axis_tvalid && s_axis_tready;

  assign sel_chain[0] = sel_q;

  for (genvar i = 0; i < BtnW; i++) begin : g_btn
    if (i < NBTN) begin : g_cell
      cell_stat_t st;
      dbsel_cell #(.ID(IdW'(i + 1))) u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .en_i    (accept),
        .raw_i   (raw[i]),
        .now_i   (now),
        .dtime_i (dtime_q),
        .sel_i   (sel_chain[i]),
        .sel_o   (sel_chain[i+1]),
        .st_o    (st)
      );
      assign deb_vec[i]     = st.deb_new;
      assign raw_chg_vec[i] = st.raw_chg;
      assign deb_chg_vec[i] = st.deb_chg;
    end else begin : g_unused
      // buttons beyond the count stay released
      assign deb_vec[i] = 1'b1;
    end
  end

  always_comb begin
    raw_chg = |raw_chg_vec;
    deb_chg = |deb_chg_vec;
    sel_d   = sel_chain[NBTN];
    if (!latch_q && (&deb_vec)) begin
      sel_d = '0;
    end
    sel_chg = (sel_d != sel_q);
    log_req = deb_chg || sel_chg || (lograw_q && raw_chg);
    led     = '0;
    if ((sel_d != '0) && (sel_d <= IdW'(NLED))) begin
      led = BtnW'(1) << (sel_d - IdW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dtime_q  <= DTIME_RESET;
      latch_q  <= 1'b1;
      lograw_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_DEBOUNCE_TIME: dtime_q  <= cfg_wdata_i;
        CFG_LATCH_MODE:    latch_q  <= cfg_wdata_i[0];
        CFG_LOG_RAW:       lograw_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        sel_q       <= sel_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= {7'd0, log_req, sel_chg, deb_chg, raw_chg, led, sel_d, deb_vec};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  // ---- assertions ----
  a_led_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> $onehot0(m_axis_tdata[36:21]))
    else $error("led pattern not one-hot");

  a_sel_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sel_q <= IdW'(NBTN))
    else $error("selection beyond button count");

  a_led_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[20:16] == '0) |-> (m_axis_tdata[36:21] == '0))
    else $error("led lit with no selection");

  a_accept_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> m_axis_tvalid)
    else $error("accepted word produced no result");

endmodule
